[hdl/bpp_pkg.sv]
// Shared types and constants for the button press pacer.
package bpp_pkg;

   localparam int OPCODE_W   = 2;
   localparam int REQ_CODE_W = 8;
   localparam int CODE_W     = 4;
   localparam int REL_W      = 10;
   localparam int GAP_W      = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [OPCODE_W-1:0] OP_TICK      = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BUTTON    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LINK_UP   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_LINK_DOWN = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_READY = 2'd2;

   localparam logic [REQ_CODE_W-1:0] MIN_CODE = 8'h01;
   localparam logic [REQ_CODE_W-1:0] MAX_CODE = 8'h0D;
   localparam logic [CODE_W-1:0]     RELEASE_CODE = 4'h0;

   localparam logic [REL_W-1:0] REL_TIMER_MAX = 10'd1023;
   localparam logic [GAP_W-1:0] GAP_TIMER_MAX = 14'd16383;

   localparam logic [REL_W-1:0] RELEASE_DELAY_RESET = 10'd100;
   localparam logic [GAP_W-1:0] MIN_GAP_RESET       = 14'd300;

   typedef struct packed {
      logic [CODE_W-1:0] report_code;
      logic              is_release;
   } report_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } queue_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[hdl/bpp_req_if.sv]
// Request channel carrying opcode and button code.
interface bpp_req_if;
   import bpp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [REQ_CODE_W-1:0] request_code;

   modport source (output valid, output opcode, output request_code, input ready);
   modport sink (input valid, input opcode, input request_code, output ready);

endinterface

[hdl/bpp_rsp_if.sv]
// Response channel carrying press and release reports.
interface bpp_rsp_if;
   import bpp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] report_code;
   logic              is_release;

   modport source (output valid, output report_code, output is_release, input ready);
   modport sink (input valid, input report_code, input is_release, output ready);

endinterface

[hdl/button_press_pacer.sv]
// Button press pacer top level: request decode, timers and report pacing.
// A report emitted on an accepted tick request is registered in the output buffer before it appears on rsp_chan.
// Throughput: one request per cycle while req_chan.ready is high; every request is handled in the cycle it is accepted.
// req_chan.ready drops only while two reports wait in the output buffer.
// Reset clears link state, queue, timers and pending release; delay 100, gap 300,
// channel ready 0.
module button_press_pacer
   import bpp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   bpp_req_if.sink               req_chan,
   bpp_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [REL_W-1:0] release_delay_ff;
   logic [GAP_W-1:0] min_gap_ff;
   logic             channel_ready_ff;

   logic             link_up_ff, link_up_in;
   logic             release_pending_ff, release_pending_in;
   logic [REL_W-1:0] release_timer_ff, release_timer_in;
   logic [GAP_W-1:0] gap_timer_ff, gap_timer_in;
   logic             sent_before_ff, sent_before_in;

   logic [REL_W-1:0]  rel_inc;
   logic [GAP_W-1:0]  gap_inc;
   logic              released;
   logic              accept;
   logic              buf_space;
   logic              emit;
   report_type        emit_report;
   queue_ctl_type     q_ctl;
   queue_status_type  q_status;
   logic [CODE_W-1:0] q_head_code;
   logic              code_ok;

   assign req_chan.ready = buf_space;
   assign accept = req_chan.valid && req_chan.ready;
   assign code_ok = (req_chan.request_code >= MIN_CODE) && (req_chan.request_code <= MAX_CODE);
   assign rel_inc = (release_timer_ff == REL_TIMER_MAX) ? release_timer_ff
                                                        : release_timer_ff + REL_W'(1);
   assign gap_inc = (gap_timer_ff == GAP_TIMER_MAX) ? gap_timer_ff
                                                    : gap_timer_ff + GAP_W'(1);

   always_comb begin
      link_up_in         = link_up_ff;
      release_pending_in = release_pending_ff;
      release_timer_in   = release_timer_ff;
      gap_timer_in       = gap_timer_ff;
      sent_before_in     = sent_before_ff;
      released           = 1'b0;
      emit               = 1'b0;
      emit_report        = '0;
      q_ctl              = '0;
      if (accept) begin
         unique case (req_chan.opcode)
            OP_TICK: begin
               gap_timer_in = gap_inc;
               if (release_pending_ff) begin
                  if (rel_inc >= release_delay_ff) begin
                     emit                   = link_up_ff && channel_ready_ff;
                     emit_report.report_code = RELEASE_CODE;
                     emit_report.is_release  = 1'b1;
                     release_pending_in     = 1'b0;
                     gap_timer_in           = '0;
                     sent_before_in         = 1'b1;
                     released               = 1'b1;
                  end else begin
                     release_timer_in = rel_inc;
                  end
               end
               if (!released && !release_pending_ff && !q_status.empty &&
                   (!sent_before_ff || (gap_inc >= min_gap_ff))) begin
                  q_ctl.pop = 1'b1;
                  if (link_up_ff) begin
                     emit                    = channel_ready_ff;
                     emit_report.report_code = q_head_code;
                     emit_report.is_release  = 1'b0;
                     release_timer_in        = '0;
                     release_pending_in      = 1'b1;
                  end
               end
            end
            OP_BUTTON: begin
               q_ctl.push = code_ok && link_up_ff && !q_status.full;
            end
            OP_LINK_UP: begin
               link_up_in = 1'b1;
            end
            OP_LINK_DOWN: begin
               link_up_in         = 1'b0;
               release_pending_in = 1'b0;
               q_ctl.clear        = 1'b1;
            end
            default: begin
               link_up_in = link_up_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff         <= 1'b0;
         release_pending_ff <= 1'b0;
         release_timer_ff   <= '0;
         gap_timer_ff       <= '0;
         sent_before_ff     <= 1'b0;
      end else begin
         link_up_ff         <= link_up_in;
         release_pending_ff <= release_pending_in;
         release_timer_ff   <= release_timer_in;
         gap_timer_ff       <= gap_timer_in;
         sent_before_ff     <= sent_before_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_delay_ff <= RELEASE_DELAY_RESET;
         min_gap_ff       <= MIN_GAP_RESET;
         channel_ready_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RELEASE_DELAY: release_delay_ff <= csr_wr_data[REL_W-1:0];
            CSR_MIN_GAP:       min_gap_ff       <= csr_wr_data[GAP_W-1:0];
            CSR_CHANNEL_READY: channel_ready_ff <= csr_wr_data[0];
            default:           channel_ready_ff <= channel_ready_ff;
         endcase
      end
   end

   bpp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (q_ctl),
      .push_code (req_chan.request_code[CODE_W-1:0]),
      .head_code (q_head_code),
      .status    (q_status)
   );

   bpp_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .push        (emit),
      .push_report (emit_report),
      .has_space   (buf_space),
      .rsp_chan    (rsp_chan)
   );

   a_report_needs_link: assert property (@(posedge clock) disable iff (reset)
      emit |-> (link_up_ff && channel_ready_ff))
      else $error("report emitted while link down or channel not ready");

   a_release_clears_pending: assert property (@(posedge clock) disable iff (reset)
      released |=> (!release_pending_ff && (gap_timer_ff == '0)))
      else $error("release did not clear pending state");

   a_link_down_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.opcode == OP_LINK_DOWN)) |=> (!link_up_ff && !release_pending_ff))
      else $error("link down left state behind");

endmodule

[hdl/bpp_queue.sv]
// Button code FIFO with prefetched head entry.
module bpp_queue
   import bpp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  queue_ctl_type     ctl,
   input  logic [CODE_W-1:0] push_code,
   output logic [CODE_W-1:0] head_code,
   output queue_status_type  status
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   logic [CODE_W-1:0] mem [QUEUE_DEPTH];
   logic [CODE_W-1:0] head_data_ff;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (ctl.pop) begin
            head_in  = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);
            count_in = count_ff - CW'(1);
         end
         if (ctl.push) begin
            tail_in  = (tail_ff == LAST_ADDR) ? '0 : tail_ff + AW'(1);
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // prefetch the entry at the next head, forward a same-cycle write
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_code;
      end
      if (ctl.push && (tail_ff == head_in)) begin
         head_data_ff <= push_code;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign head_code    = head_data_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_COUNT);

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !status.empty)
      else $error("pop from empty queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> !status.full)
      else $error("push into full queue");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> status.empty)
      else $error("queue not empty after clear");

endmodule

[hdl/bpp_rsp_buffer.sv]
// Two-entry output buffer for reports.
module bpp_rsp_buffer
   import bpp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  report_type push_report,
   output logic       has_space,
   bpp_rsp_if.source  rsp_chan
);

   report_type  entry_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign has_space = (count_ff != 2'd2);

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_report;
      end
   end

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.report_code = entry_ff[rd_ptr_ff].report_code;
   assign rsp_chan.is_release  = entry_ff[rd_ptr_ff].is_release;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> has_space)
      else $error("report buffer overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("report buffer count out of range");

endmodule
